[sv/csx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package csx_pkg;

	// Payload bytes the frame port can carry; never more than the 64-bit field.
	localparam int PAYLOAD_BYTES = 8;
	localparam int MAX_BYTES     = (PAYLOAD_BYTES < 8) ? PAYLOAD_BYTES : 8;

	localparam int EXT_ID_BITS = 29;
	localparam int STD_ID_BITS = 11;

	localparam int CFG_DATA_W = 48;

	localparam logic [31:0] Q_UNITY = 32'h0001_0000;

	typedef enum logic [2:0] {
		REG_DATA_SOURCE    = 3'd0,
		REG_START_BIT      = 3'd1,
		REG_BIT_LENGTH     = 3'd2,
		REG_BYTE_ORDER     = 3'd3,
		REG_VALUE_FORMAT   = 3'd4,
		REG_CONVERT_ENABLE = 3'd5,
		REG_GAIN           = 3'd6,
		REG_OFFSET         = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		FMT_SIGNED   = 3'd0,
		FMT_UNSIGNED = 3'd1,
		FMT_FLOAT32  = 3'd2,
		FMT_FLOAT64  = 3'd3,
		FMT_ASCII    = 3'd4
	} value_fmt_t;

endpackage

`default_nettype wire

[sv/csx_frame_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface csx_frame_if;
	logic        valid;
	logic        ready;
	logic [28:0] frame_id;
	logic        extended_format;
	logic [63:0] payload_bits;
	logic [3:0]  payload_bytes;

	modport source (output valid, frame_id, extended_format, payload_bits, payload_bytes,
		input ready);
	modport sink (input valid, frame_id, extended_format, payload_bits, payload_bytes,
		output ready);
endinterface

`default_nettype wire

[sv/csx_result_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface csx_result_if;
	logic               valid;
	logic               ready;
	logic               status;
	logic [63:0]        raw_value;
	logic signed [63:0] scaled_value;

	modport source (output valid, status, raw_value, scaled_value, input ready);
	modport sink (input valid, status, raw_value, scaled_value, output ready);
endinterface

`default_nettype wire

[sv/can_signal_extract.sv]
`timescale 1ns / 1ps
`default_nettype none

// Each frame transfer passes through registered stages 1 to 7, and its result is offered
// from the stage 7 output register.
// Throughput: one frame per cycle while result.ready holds; every stage, multipliers included, can load each cycle.
// Each stage holds when the one after it is full and stalled, so bubbles are squeezed out.
// Reset (arst_n low, asynchronous): all stage valid bits clear, config registers
// return to data_source 0, start_bit 0, bit_length 8, little endian, unsigned,
// conversion off, gain 1.0, offset 0.
module can_signal_extract
	import csx_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	csx_frame_if.sink                  frame,
	csx_result_if.source               result,
	input  wire logic                  cfg_we,
	input  wire logic [2:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	//------------------------------------------------------------------
	// Configuration registers
	//------------------------------------------------------------------
	logic        data_source_q;
	logic [5:0]  start_bit_q;
	logic [6:0]  bit_length_q;
	logic        byte_order_q;
	logic [2:0]  value_format_q;
	logic        convert_enable_q;
	logic [31:0] gain_q;
	logic [47:0] offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_source_q    <= 1'b0;
			start_bit_q      <= 6'd0;
			bit_length_q     <= 7'd8;
			byte_order_q     <= 1'b0;
			value_format_q   <= FMT_UNSIGNED;
			convert_enable_q <= 1'b0;
			gain_q           <= Q_UNITY;
			offset_q         <= 48'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DATA_SOURCE:    data_source_q    <= cfg_wdata[0];
				REG_START_BIT:      start_bit_q      <= cfg_wdata[5:0];
				REG_BIT_LENGTH:     bit_length_q     <= cfg_wdata[6:0];
				REG_BYTE_ORDER:     byte_order_q     <= cfg_wdata[0];
				REG_VALUE_FORMAT:   value_format_q   <= cfg_wdata[2:0];
				REG_CONVERT_ENABLE: convert_enable_q <= cfg_wdata[0];
				REG_GAIN:           gain_q           <= cfg_wdata[31:0];
				REG_OFFSET:         offset_q         <= cfg_wdata[47:0];
				default: begin
				end
			endcase
		end
	end

	// The user must change config only while the pipe is empty (not enforced here); stages read it directly.
	logic fmt_signed, fmt_int, fmt_reorder;
	assign fmt_signed  = (value_format_q == FMT_SIGNED);
	assign fmt_int     = !((value_format_q == FMT_FLOAT32) || (value_format_q == FMT_FLOAT64)
		|| (value_format_q == FMT_ASCII));
	// ASCII keeps stream order whatever byte_order says
	assign fmt_reorder = byte_order_q && (value_format_q != FMT_ASCII);

	logic [63:0] len_mask;
	assign len_mask = ~({64{1'b1}} << bit_length_q);

	//------------------------------------------------------------------
	// Stall chain: a stage may load when it is empty or its contents move on.
	//------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = !v_s7 || result.ready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign frame.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= frame.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	//------------------------------------------------------------------
	// Stage 1: pick source, range check, shift and mask the field
	//------------------------------------------------------------------
	logic [3:0]  nbytes_c;
	logic [6:0]  max_bits_c;
	logic [7:0]  end_bit_c;
	logic        bad_c;
	logic [63:0] data_c;
	logic [63:0] stream_c;

	always_comb begin
		nbytes_c = (frame.payload_bytes > 4'(MAX_BYTES)) ? 4'(MAX_BYTES) : frame.payload_bytes;
		if (data_source_q) begin
			data_c     = {35'd0, frame.frame_id};
			max_bits_c = frame.extended_format ? 7'(EXT_ID_BITS) : 7'(STD_ID_BITS);
		end else begin
			data_c     = frame.payload_bits;
			max_bits_c = {nbytes_c, 3'b000};
		end
		end_bit_c = {2'b00, start_bit_q} + {1'b0, bit_length_q};
		bad_c     = (bit_length_q == 7'd0) || (end_bit_c > {1'b0, max_bits_c});
		stream_c  = (data_c >> start_bit_q) & len_mask;
	end

	logic        bad_s1;
	logic [63:0] stream_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			bad_s1    <= bad_c;
			stream_s1 <= stream_c;
		end
	end

	//------------------------------------------------------------------
	// Stage 2: big-endian byte-group reorder, partial group on top
	//------------------------------------------------------------------
	logic [2:0]  part_bits;
	logic [3:0]  full_grps;
	logic [63:0] full_part, bswap, rev_c, part_c, raw_be_c;

	always_comb begin
		part_bits = bit_length_q[2:0];
		full_grps = bit_length_q[6:3];
		full_part = stream_s1 >> part_bits;
		for (int b = 0; b < 8; b++) begin
			bswap[8*b +: 8] = full_part[8*(7-b) +: 8];
		end
		rev_c    = bswap >> (7'd64 - {full_grps, 3'b000});
		part_c   = stream_s1 & ~({64{1'b1}} << part_bits);
		raw_be_c = rev_c | (part_c << {full_grps, 3'b000});
	end

	logic        bad_s2;
	logic [63:0] raw_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			bad_s2 <= bad_s1;
			raw_s2 <= fmt_reorder ? raw_be_c : stream_s1;
		end
	end

	//------------------------------------------------------------------
	// Stage 3: sign extension, split into sign and magnitude
	//------------------------------------------------------------------
	logic        top_bit;
	logic [63:0] sext_c;
	logic        neg_c;

	always_comb begin
		top_bit = raw_s2[6'(bit_length_q - 7'd1)];
		sext_c  = raw_s2;
		if (fmt_signed && (bit_length_q < 7'd64) && top_bit) begin
			sext_c = raw_s2 | ~len_mask;
		end
		neg_c = fmt_signed && sext_c[63];
	end

	logic        bad_s3, neg_s3;
	logic [63:0] raw_s3, mag_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			bad_s3 <= bad_s2;
			raw_s3 <= sext_c;
			neg_s3 <= neg_c;
			mag_s3 <= neg_c ? (64'd0 - sext_c) : sext_c;
		end
	end

	//------------------------------------------------------------------
	// Stage 4: |raw| * |gain| as two 32x32 partial products
	//------------------------------------------------------------------
	logic [31:0] gain_eff, mag_g;
	logic        neg_g;

	assign gain_eff = convert_enable_q ? gain_q : Q_UNITY;
	assign neg_g    = gain_eff[31];
	assign mag_g    = neg_g ? (32'd0 - gain_eff) : gain_eff;

	logic        bad_s4, neg_p_s4;
	logic [63:0] raw_s4, p_lo_s4, p_hi_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			bad_s4   <= bad_s3;
			raw_s4   <= raw_s3;
			p_lo_s4  <= mag_s3[31:0] * mag_g;
			p_hi_s4  <= mag_s3[63:32] * mag_g;
			neg_p_s4 <= (neg_s3 != neg_g) && (mag_s3 != 64'd0) && (mag_g != 32'd0);
		end
	end

	//------------------------------------------------------------------
	// Stage 5: combine partial products into the 96-bit magnitude
	//------------------------------------------------------------------
	logic [95:0] prod_c;
	assign prod_c = {32'd0, p_lo_s4} + {p_hi_s4, 32'd0};

	logic        bad_s5, neg_p_s5, hi_nz_s5;
	logic [63:0] raw_s5, low_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			bad_s5   <= bad_s4;
			raw_s5   <= raw_s4;
			neg_p_s5 <= neg_p_s4;
			low_s5   <= prod_c[63:0];
			hi_nz_s5 <= |prod_c[95:64];
		end
	end

	//------------------------------------------------------------------
	// Stage 6: signed add of the offset on sign/magnitude values
	//------------------------------------------------------------------
	logic [47:0] off_eff, mag_o;
	logic        neg_o;
	logic [64:0] sum_c;
	logic [63:0] d_po_c, d_op_c;
	logic        res_neg_c, res_over_c;
	logic [63:0] res_mag_c;

	always_comb begin
		off_eff = convert_enable_q ? offset_q : 48'd0;
		neg_o   = off_eff[47];
		mag_o   = neg_o ? (48'd0 - off_eff) : off_eff;
		sum_c   = {1'b0, low_s5} + {17'd0, mag_o};
		d_po_c  = low_s5 - {16'd0, mag_o};
		d_op_c  = {16'd0, mag_o} - low_s5;
		if (neg_p_s5 == neg_o) begin
			res_neg_c  = neg_p_s5;
			res_mag_c  = sum_c[63:0];
			res_over_c = hi_nz_s5 || sum_c[64];
		end else if (hi_nz_s5) begin
			res_neg_c  = neg_p_s5;
			res_mag_c  = 64'd0;
			res_over_c = 1'b1;
		end else if (low_s5 >= {16'd0, mag_o}) begin
			res_neg_c  = neg_p_s5;
			res_mag_c  = d_po_c;
			res_over_c = 1'b0;
		end else begin
			res_neg_c  = neg_o;
			res_mag_c  = d_op_c;
			res_over_c = 1'b0;
		end
	end

	logic        bad_s6, res_neg_s6, res_over_s6;
	logic [63:0] raw_s6, res_mag_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			bad_s6      <= bad_s5;
			raw_s6      <= raw_s5;
			res_neg_s6  <= res_neg_c;
			res_mag_s6  <= res_mag_c;
			res_over_s6 <= res_over_c;
		end
	end

	//------------------------------------------------------------------
	// Stage 7: saturate to signed 64 bits; output register
	//------------------------------------------------------------------
	logic [63:0] sat_c;

	always_comb begin
		if (!res_neg_s6) begin
			sat_c = (res_over_s6 || res_mag_s6[63]) ? {1'b0, {63{1'b1}}} : res_mag_s6;
		end else if (res_over_s6 || (res_mag_s6 > {1'b1, 63'd0})) begin
			sat_c = {1'b1, 63'd0};
		end else begin
			sat_c = 64'd0 - res_mag_s6;
		end
	end

	logic        status_s7;
	logic [63:0] raw_s7, scaled_s7;

	always_ff @(posedge clk) begin
		if (en7) begin
			status_s7 <= bad_s6;
			raw_s7    <= bad_s6 ? 64'd0 : raw_s6;
			scaled_s7 <= (bad_s6 || !fmt_int) ? 64'd0 : sat_c;
		end
	end

	assign result.valid        = v_s7;
	assign result.status       = status_s7;
	assign result.raw_value    = raw_s7;
	assign result.scaled_value = scaled_s7;

	//------------------------------------------------------------------
	// Assertions
	//------------------------------------------------------------------
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status) |-> (result.raw_value == 64'd0
		&& result.scaled_value == 64'sd0))
		else $error("out-of-range frame produced a nonzero value");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> frame.ready)
		else $error("input stalled with empty output stage");

	a_bubble_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !v_s2) |=> v_s2)
		else $error("stage 1 item did not advance into empty stage 2");

	a_neg_mag: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && neg_s3) |-> (mag_s3 != 64'd0))
		else $error("negative value with zero magnitude");

endmodule

`default_nettype wire
